// ===== hw/rtl/erast_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erast_pkg: shared types and constants for the ellipse outline rasterizer
// Field widths, derived datapath widths, opcodes and the command record that
// travels from the front end through the command queue to the step engine.
// ----------------------------------------------------------------------------
package erast_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 12;
  localparam int CENTER_BITS = 15;
  localparam int COLOR_BITS  = 32;

  localparam int STEPX_BITS = RADIUS_BITS + 1;
  localparam int SQ_BITS    = 2 * RADIUS_BITS;
  localparam int MULB_BITS  = RADIUS_BITS + 2;
  localparam int PROD_BITS  = SQ_BITS + MULB_BITS;
  localparam int ERR_BITS   = 4 * RADIUS_BITS;
  localparam int WIDE_BITS  = COORD_BITS + RADIUS_BITS + 2;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic                          start;
    logic signed [CENTER_BITS-1:0] cx;
    logic signed [CENTER_BITS-1:0] cy;
    logic [RADIUS_BITS-1:0]        rad_a;
    logic [RADIUS_BITS-1:0]        rad_b;
    logic [COLOR_BITS-1:0]         color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ellipse_outline_rasterizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_outline_rasterizer: axis-aligned ellipse outline generator
// Traces one quadrant of an ellipse and returns four mirrored points per step.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode start loads centre, radii and
// colour and returns nothing; opcode next performs one point step and
// returns one group on the output channel (nothing if no ellipse is active).
// Output channel (out_valid/out_ready): one group of corners per next item,
// last_group set on the final group, after which the block is idle again.
// Path: a next item passes the input register, the command queue and the
// engine's fetch / multiply / accumulate sequence around its single
// multiplier; a start item runs the engine through its set-up states.
// The engine takes no new item until it has finished the one before.
// An input register and a two-entry command queue sit in front of the
// engine, so up to three items are taken while the engine is busy.
// Reset: no ellipse is active; next items are dropped until a start arrives.
// Receiver stall: the engine holds its step until the output register frees,
// the queue fills, and then in_ready falls.
// ----------------------------------------------------------------------------
module ellipse_outline_rasterizer (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  [0:0]                               opcode,
  input  wire  signed [erast_pkg::CENTER_BITS-1:0] center_x,
  input  wire  signed [erast_pkg::CENTER_BITS-1:0] center_y,
  input  wire  [erast_pkg::RADIUS_BITS-1:0]        radius_x,
  input  wire  [erast_pkg::RADIUS_BITS-1:0]        radius_y,
  input  wire  [erast_pkg::COLOR_BITS-1:0]         pixel_value,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic signed [erast_pkg::COORD_BITS-1:0]  left_x,
  output logic signed [erast_pkg::COORD_BITS-1:0]  right_x,
  output logic signed [erast_pkg::COORD_BITS-1:0]  top_y,
  output logic signed [erast_pkg::COORD_BITS-1:0]  bottom_y,
  output logic [erast_pkg::COLOR_BITS-1:0]         point_color,
  output logic [0:0]                               last_group
);

  logic               f_valid;
  logic               f_ready;
  erast_pkg::cmd_t    f_cmd;
  logic               q_valid;
  logic               q_ready;
  erast_pkg::cmd_t    q_cmd;
  erast_pkg::q_stat_t q_stat;
  logic               drawing;

  erast_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .pixel_value (pixel_value),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  erast_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd),
    .stat       (q_stat)
  );

  erast_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_x      (left_x),
    .right_x     (right_x),
    .top_y       (top_y),
    .bottom_y    (bottom_y),
    .point_color (point_color),
    .last_group  (last_group),
    .drawing     (drawing)
  );

`ifndef SYNTHESIS
  a_queue_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("command queue reports full and empty together");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && last_group[0] |-> !drawing)
    else $error("final group issued while ellipse still active");

  a_emit_drawing: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(drawing))
    else $error("group issued with no active ellipse");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/erast_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erast_front: input stage
// Accepts input items, decodes the opcode and holds one command record for
// the command queue.
// ----------------------------------------------------------------------------
module erast_front (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire  [0:0]                                 opcode,
  input  wire  signed [erast_pkg::CENTER_BITS-1:0]   center_x,
  input  wire  signed [erast_pkg::CENTER_BITS-1:0]   center_y,
  input  wire  [erast_pkg::RADIUS_BITS-1:0]          radius_x,
  input  wire  [erast_pkg::RADIUS_BITS-1:0]          radius_y,
  input  wire  [erast_pkg::COLOR_BITS-1:0]           pixel_value,
  output logic                                       cmd_valid,
  input  wire                                        cmd_ready,
  output erast_pkg::cmd_t                            cmd
);

  assign in_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.start <= (opcode[0] == erast_pkg::OP_START);
      cmd.cx    <= center_x;
      cmd.cy    <= center_y;
      cmd.rad_a <= radius_x;
      cmd.rad_b <= radius_y;
      cmd.color <= pixel_value;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/erast_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erast_queue: command queue
// Short register FIFO between the front end and the step engine so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module erast_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push_valid,
  output logic               push_ready,
  input  erast_pkg::cmd_t    push_data,
  output logic               pop_valid,
  input  wire                pop_ready,
  output erast_pkg::cmd_t    pop_data,
  output erast_pkg::q_stat_t stat
);

  erast_pkg::cmd_t                     entries [erast_pkg::Q_DEPTH];
  logic [erast_pkg::Q_PTR_BITS-1:0]    wr_ptr;
  logic [erast_pkg::Q_PTR_BITS-1:0]    rd_ptr;
  logic [erast_pkg::Q_CNT_BITS-1:0]    count;
  logic                                do_push;
  logic                                do_pop;

  function automatic logic [erast_pkg::Q_PTR_BITS-1:0] bump(
    input logic [erast_pkg::Q_PTR_BITS-1:0] p
  );
    if (p == erast_pkg::Q_PTR_BITS'(erast_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + erast_pkg::Q_PTR_BITS'(1);
  endfunction

  assign stat.full  = (count == erast_pkg::Q_CNT_BITS'(erast_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + erast_pkg::Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - erast_pkg::Q_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/erast_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erast_back: step engine
// Sequences one shared multiplier through the start set-up (a*a, b*b, b*b*a)
// and through each point step, updates the error term and loads the output
// register with one group of four mirrored points.
// ----------------------------------------------------------------------------
module erast_back (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cmd_valid,
  output logic                                    cmd_ready,
  input  erast_pkg::cmd_t                         cmd,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [erast_pkg::COORD_BITS-1:0] left_x,
  output logic signed [erast_pkg::COORD_BITS-1:0] right_x,
  output logic signed [erast_pkg::COORD_BITS-1:0] top_y,
  output logic signed [erast_pkg::COORD_BITS-1:0] bottom_y,
  output logic [erast_pkg::COLOR_BITS-1:0]        point_color,
  output logic [0:0]                              last_group,
  output logic                                    drawing
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQA    = 3'd1;
  localparam logic [2:0] ST_SQB    = 3'd2;
  localparam logic [2:0] ST_BIAS   = 3'd3;
  localparam logic [2:0] ST_SETERR = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_APPLY  = 3'd6;

  localparam int WB = erast_pkg::WIDE_BITS;
  localparam int CB = erast_pkg::COORD_BITS;

  logic [2:0]                                state;
  logic [erast_pkg::RADIUS_BITS-1:0]         rad_a;
  logic [erast_pkg::SQ_BITS-1:0]             a_sq;
  logic [erast_pkg::SQ_BITS-1:0]             b_sq;
  logic [erast_pkg::STEPX_BITS-1:0]          step_x;
  logic [erast_pkg::RADIUS_BITS-1:0]         step_y;
  logic signed [erast_pkg::ERR_BITS-1:0]     err;
  logic signed [erast_pkg::CENTER_BITS-1:0]  cx;
  logic signed [erast_pkg::CENTER_BITS-1:0]  cy;
  logic [erast_pkg::COLOR_BITS-1:0]          color;
  logic                                      neg;
  logic [erast_pkg::PROD_BITS-1:0]           prod;

  logic [erast_pkg::SQ_BITS-1:0]             mul_a;
  logic [erast_pkg::MULB_BITS-1:0]           mul_b;
  logic [erast_pkg::STEPX_BITS-1:0]          x_new;
  logic [WB-1:0]                             xm1_w;
  logic [WB-1:0]                             cx_w;
  logic [WB-1:0]                             cy_w;
  logic [WB-1:0]                             y_w;
  logic [WB-1:0]                             lx_w;
  logic [WB-1:0]                             rx_w;
  logic [WB-1:0]                             ty_w;
  logic [WB-1:0]                             by_w;
  logic [erast_pkg::ERR_BITS-1:0]            err_next;
  logic                                      last;
  logic                                      apply_fire;

  assign cmd_ready  = (state == ST_IDLE);
  assign apply_fire = (state == ST_APPLY) && (!out_valid || out_ready);

  // shared multiplier operands
  always_comb begin
    unique case (state)
      ST_SQA: begin
        mul_a = erast_pkg::SQ_BITS'(rad_a);
        mul_b = erast_pkg::MULB_BITS'(rad_a);
      end
      ST_SQB: begin
        mul_a = erast_pkg::SQ_BITS'(step_y);
        mul_b = erast_pkg::MULB_BITS'(step_y);
      end
      ST_BIAS: begin
        mul_a = prod[erast_pkg::SQ_BITS-1:0];
        mul_b = erast_pkg::MULB_BITS'(rad_a);
      end
      ST_MUL: begin
        if (neg) begin
          mul_a = b_sq;
          mul_b = {step_x, 1'b1};
        end else begin
          mul_a = a_sq;
          mul_b = {1'b0, step_y, 1'b0};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // point step: error update and mirrored corners
  always_comb begin
    x_new = neg ? step_x + erast_pkg::STEPX_BITS'(1) : step_x;
    xm1_w = WB'(x_new) - WB'(1);
    cx_w  = WB'(cx);
    cy_w  = WB'(cy);
    y_w   = WB'(step_y);
    lx_w  = cx_w - xm1_w;
    rx_w  = cx_w + xm1_w;
    ty_w  = cy_w - y_w;
    by_w  = cy_w + y_w;
    if (neg) begin
      err_next = err + erast_pkg::ERR_BITS'(prod);
    end else begin
      err_next = err + erast_pkg::ERR_BITS'(a_sq) - erast_pkg::ERR_BITS'(prod);
    end
    last = !neg && (step_y == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      drawing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.start) begin
              drawing <= 1'b0;
              state   <= ST_SQA;
            end else if (drawing) begin
              state <= ST_MUL;
            end
          end
        end
        ST_SQA:    state <= ST_SQB;
        ST_SQB:    state <= ST_BIAS;
        ST_BIAS:   state <= ST_SETERR;
        ST_SETERR: begin
          drawing <= 1'b1;
          state   <= ST_IDLE;
        end
        ST_MUL:    state <= ST_APPLY;
        ST_APPLY: begin
          if (apply_fire) begin
            out_valid <= 1'b1;
            if (last) begin
              drawing <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      if (cmd.start) begin
        cx     <= cmd.cx;
        cy     <= cmd.cy;
        rad_a  <= cmd.rad_a;
        step_y <= cmd.rad_b;
        step_x <= '0;
        color  <= cmd.color;
      end else begin
        neg <= err[erast_pkg::ERR_BITS-1];
      end
    end
    if (state == ST_SQA || state == ST_SQB || state == ST_BIAS || state == ST_MUL) begin
      prod <= erast_pkg::PROD_BITS'(mul_a) * erast_pkg::PROD_BITS'(mul_b);
    end
    if (state == ST_SQB) begin
      a_sq <= prod[erast_pkg::SQ_BITS-1:0];
    end
    if (state == ST_BIAS) begin
      b_sq <= prod[erast_pkg::SQ_BITS-1:0];
    end
    if (state == ST_SETERR) begin
      err <= -$signed(erast_pkg::ERR_BITS'(prod));
    end
    if (apply_fire) begin
      err    <= err_next;
      step_x <= x_new;
      if (!neg && step_y != '0) begin
        step_y <= step_y - erast_pkg::RADIUS_BITS'(1);
      end
      left_x      <= lx_w[CB-1:0];
      right_x     <= rx_w[CB-1:0];
      top_y       <= ty_w[CB-1:0];
      bottom_y    <= by_w[CB-1:0];
      point_color <= color;
      last_group  <= last;
    end
  end

endmodule
`default_nettype wire
